// ===== src/lz77rd_pkg.sv =====
// ----------------------------------------------------------------------------
// lz77rd_pkg - shared constants and types of the LZ77 record decompressor
// Record geometry, token field widths and the structs that pass between the
// token engine, the history memory and the top level.
// ----------------------------------------------------------------------------
package lz77rd_pkg;

   // Record size in bytes and the number of length bits in a back-reference.
   localparam int RECORD_BYTES = 4096;
   localparam int LENGTH_BITS  = 3;

   // Derived widths.
   localparam int ADDR_W = $clog2(RECORD_BYTES);
   localparam int POS_W  = $clog2(RECORD_BYTES + 1);
   localparam int DIST_W = 14 - LENGTH_BITS;
   localparam int LEN_W  = $clog2((1 << LENGTH_BITS) + 3);
   localparam int WIDE_W = (POS_W > DIST_W) ? POS_W : DIST_W;

   // Token byte codes.
   localparam logic [7:0] RAW_MAX     = 8'h08;
   localparam logic [7:0] LITERAL_MAX = 8'h7F;
   localparam logic [7:0] PAIR_MIN    = 8'hC0;
   localparam logic [7:0] PAIR_FLIP   = 8'h80;
   localparam logic [7:0] SPACE_CHAR  = 8'h20;
   localparam int         LEN_BIAS    = 3;

   // One decompressed byte leaving the engine.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
      logic       bad;
   } emit_type;

   // History memory access for one cycle.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

// ===== src/lz77rd_hist_mem.sv =====
// ----------------------------------------------------------------------------
// lz77rd_hist_mem - history memory of the current record
// One write port and one read port with registered read data. A read of the
// entry written in the same cycle returns the new byte.
// ----------------------------------------------------------------------------
module lz77rd_hist_mem (
   input  logic                    clock,
   input  lz77rd_pkg::mem_req_type mem_req,
   output logic [7:0]              rd_data
);
   import lz77rd_pkg::*;

   logic [7:0] history_ff [RECORD_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         history_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Forwarding covers a copy at distance one, where the next source byte is
   // the one being written.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         if (mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_addr)) begin
            rd_data_ff <= mem_req.wr_data;
         end else begin
            rd_data_ff <= history_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lz77rd_engine.sv =====
// ----------------------------------------------------------------------------
// lz77rd_engine - token parser and copy sequencer
// Decodes one compressed byte per accepted transfer and emits output bytes one
// per cycle while out_free is high, reading copy sources from history memory.
// ----------------------------------------------------------------------------
module lz77rd_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_byte,
   input  logic                    req_last,
   input  logic                    out_free,
   output lz77rd_pkg::emit_type    emit,
   output lz77rd_pkg::mem_req_type mem_req,
   input  logic [7:0]              rd_data
);
   import lz77rd_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PAIR,
      S_WAIT,
      S_COPY
   } state_type;

   state_type         state_ff, state_in;
   logic [POS_W-1:0]  wp_ff, wp_in;
   logic [3:0]        raw_ff, raw_in;
   logic [7:0]        pend_high_ff, pend_high_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              last_rec_ff, last_rec_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic              bad_ff, bad_in;
   logic [7:0]        pair_ff, pair_in;

   logic              full;
   logic              near_end;
   logic              accept;
   logic              done;
   logic [15:0]       word;
   logic [DIST_W-1:0] ref_dist;

   assign full     = (wp_ff >= POS_W'(RECORD_BYTES));
   assign near_end = (wp_ff == POS_W'(RECORD_BYTES - 1));
   assign accept   = req_tvalid && req_tready;
   assign word     = {pend_high_ff, req_byte};
   assign ref_dist = word[13:LENGTH_BITS];

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      raw_in        = raw_ff;
      pend_high_in  = pend_high_ff;
      pend_valid_in = pend_valid_ff;
      last_rec_in   = last_rec_ff;
      cnt_in        = cnt_ff;
      src_in        = src_ff;
      bad_in        = bad_ff;
      pair_in       = pair_ff;
      emit          = '0;
      mem_req       = '0;
      done          = 1'b0;
      req_tready    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = out_free;
            if (accept) begin
               last_rec_in = req_last;
               if (raw_ff != 4'd0) begin
                  raw_in     = raw_ff - 4'd1;
                  emit.valid = !full;
                  emit.data  = req_byte;
                  emit.last  = 1'b1;
                  done       = 1'b1;
               end else if (pend_valid_ff) begin
                  pend_valid_in   = 1'b0;
                  cnt_in          = LEN_W'(word[LENGTH_BITS-1:0]) + LEN_W'(LEN_BIAS);
                  bad_in          = (ref_dist == '0) ||
                                    (WIDE_W'(ref_dist) > WIDE_W'(wp_ff));
                  src_in          = ADDR_W'(WIDE_W'(wp_ff) - WIDE_W'(ref_dist));
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = src_in;
                  if (full) begin
                     done = 1'b1;
                  end else begin
                     state_in = S_WAIT;
                  end
               end else if (req_byte inside {[8'h01:RAW_MAX]}) begin
                  raw_in = req_byte[3:0];
                  done   = 1'b1;
               end else if (req_byte <= LITERAL_MAX) begin
                  emit.valid = !full;
                  emit.data  = req_byte;
                  emit.last  = 1'b1;
                  done       = 1'b1;
               end else if (req_byte >= PAIR_MIN) begin
                  emit.valid = !full;
                  emit.data  = SPACE_CHAR;
                  emit.last  = near_end;
                  pair_in    = req_byte ^ PAIR_FLIP;
                  if (full) begin
                     done = 1'b1;
                  end else begin
                     state_in = S_PAIR;
                  end
               end else begin
                  pend_high_in  = req_byte;
                  pend_valid_in = 1'b1;
                  done          = 1'b1;
               end
            end
         end
         S_PAIR: begin
            if (full) begin
               done = 1'b1;
            end else if (out_free) begin
               emit.valid = 1'b1;
               emit.data  = pair_ff;
               emit.last  = 1'b1;
               done       = 1'b1;
            end
         end
         S_WAIT: begin
            state_in = S_COPY;
         end
         S_COPY: begin
            if (full) begin
               done = 1'b1;
            end else if (out_free) begin
               emit.valid = 1'b1;
               emit.data  = bad_ff ? 8'h00 : rd_data;
               emit.bad   = bad_ff;
               emit.last  = (cnt_ff == LEN_W'(1)) || near_end;
               cnt_in     = cnt_ff - LEN_W'(1);
               src_in     = ADDR_W'(src_ff + ADDR_W'(1));
               if (cnt_ff == LEN_W'(1)) begin
                  done = 1'b1;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = src_in;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Every emitted byte is appended to the history.
      if (emit.valid) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = ADDR_W'(wp_ff);
         mem_req.wr_data = emit.data;
         wp_in           = wp_ff + POS_W'(1);
      end

      if (done) begin
         state_in = S_IDLE;
         if ((state_ff == S_IDLE) ? req_last : last_rec_ff) begin
            wp_in         = '0;
            raw_in        = 4'd0;
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wp_ff         <= '0;
         raw_ff        <= 4'd0;
         pend_high_ff  <= 8'h00;
         pend_valid_ff <= 1'b0;
         last_rec_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         raw_ff        <= raw_in;
         pend_high_ff  <= pend_high_in;
         pend_valid_ff <= pend_valid_in;
         last_rec_ff   <= last_rec_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      src_ff  <= src_in;
      bad_ff  <= bad_in;
      pair_ff <= pair_in;
   end

   a_emit_within_record: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> !full)
      else $error("byte emitted beyond the record");

   a_emit_writes_history: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> (mem_req.wr_en && (mem_req.wr_data == emit.data)))
      else $error("emitted byte not stored in history");

   a_wait_then_copy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> (!emit.valid ##1 (state_ff == S_COPY)))
      else $error("copy read latency cycle broken");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit.bad) |-> (emit.data == 8'h00))
      else $error("bad distance byte is not zero");

   a_copy_read_issued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && accept && pend_valid_ff && raw_ff == 4'd0 && !full)
      |-> mem_req.rd_en)
      else $error("back-reference started without a source read");

endmodule

// ===== src/lz77_record_decompressor.sv =====
// ----------------------------------------------------------------------------
// lz77_record_decompressor - streaming LZ77 record decompressor
// Takes compressed record bytes one transfer at a time and returns the
// decompressed bytes, copying back-references from an on-chip history memory.
// ----------------------------------------------------------------------------
//
// Channel  Direction  tdata             tlast           tuser
// req_     in         [7:0] in_byte     last_in_record  -
// rsp_     out        [7:0] out_byte    last_of_run     bad_distance
//
// A literal or raw-run byte is taken and enters the output register on the
// next edge. A space pair emits the space, then its second byte from S_PAIR.
// A back-reference reads history on its tail byte, waits in S_WAIT, then
// copies 3 to 10 bytes, one per cycle while the output is free; the single
// history read port sets that pace. Reset clears the write position and the
// token state; the history memory needs no clearing. When rsp_tready is low
// the result waits in the output register and the engine holds its place.
// ----------------------------------------------------------------------------
module lz77_record_decompressor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // last_in_record
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last_of_run
   output logic       rsp_tuser    // bad_distance
);
   import lz77rd_pkg::*;

   emit_type    emit;
   mem_req_type mem_req;
   logic [7:0]  rd_data;
   logic        out_free;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff;
   logic        rsp_last_ff;
   logic        rsp_bad_ff;

   // The output register can take a new byte when it is empty or its byte
   // leaves in this cycle's transfer.
   assign out_free = !rsp_valid_ff || rsp_tready;

   lz77rd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .out_free   (out_free),
      .emit       (emit),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

   lz77rd_hist_mem u_hist_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The engine only emits when out_free is high, so loading never overwrites
   // a byte that has not been transferred.
   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_data_ff <= emit.data;
         rsp_last_ff <= emit.last;
         rsp_bad_ff  <= emit.bad;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !emit.valid)
      else $error("waiting result overwritten");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result changed");

   a_no_accept_on_full_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while output blocked");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for lz77_record_decompressor
// Drives compressed record bytes into the request stream and checks every
// response transfer against a behavioral decoder kept in step with the
// accepted inputs. A directed table comes first, then one record filled to
// capacity, then a random mix of well-formed tokens with some noise.
// ----------------------------------------------------------------------------
module testbench;
   import lz77rd_pkg::*;

   localparam int          RESET_CYCLES  = 3;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          TAIL_CYCLES   = 24;
   localparam int          RANDOM_ITEMS  = 450;
   localparam int          NUM_DIRECTED  = 25;
   localparam int          MAX_DIST      = (1 << DIST_W) - 1;
   localparam int          MAX_LEN_CODE  = (1 << LENGTH_BITS) - 1;
   localparam logic [15:0] WORD_MASK     = 16'h3FFF;
   localparam int          TIMEOUT_NS    = 100_000_000;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;  // [7:0] in_byte
   logic       req_tlast  = 1'b0;   // last_in_record
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;           // last_of_run
   logic       rsp_tuser;           // bad_distance

   lz77_record_decompressor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // One decompressed byte as the response stream should carry it.
   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       bad;
   } out_byte_type;

   typedef enum logic {ROW_PREDICTED, ROW_TYPED} row_kind_type;

   // A directed row; typed rows carry their response in count/val/bad.
   typedef struct packed {
      logic [7:0]   data;
      logic         rec_last;
      row_kind_type kind;
      logic [3:0]   count;
      logic [7:0]   val;
      logic         bad;
   } row_type;

   row_type directed_rows [NUM_DIRECTED] = '{
      '{8'h00, 1'b0, ROW_TYPED,     4'd1,  8'h00, 1'b0},  // literal zero
      '{8'h7F, 1'b0, ROW_TYPED,     4'd1,  8'h7F, 1'b0},  // highest literal
      '{8'h09, 1'b0, ROW_TYPED,     4'd1,  8'h09, 1'b0},  // lowest literal above runs
      '{8'h80, 1'b0, ROW_TYPED,     4'd0,  8'h00, 1'b0},  // back-reference head
      '{8'h08, 1'b0, ROW_PREDICTED, 4'd0,  8'h00, 1'b0},  // distance 1, overlapping copy
      '{8'hBF, 1'b0, ROW_TYPED,     4'd0,  8'h00, 1'b0},
      '{8'hFF, 1'b0, ROW_TYPED,     4'd10, 8'h00, 1'b1},  // farthest distance, longest copy
      '{8'h80, 1'b0, ROW_TYPED,     4'd0,  8'h00, 1'b0},
      '{8'h00, 1'b0, ROW_TYPED,     4'd3,  8'h00, 1'b1},  // distance zero
      '{8'hC0, 1'b0, ROW_PREDICTED, 4'd0,  8'h00, 1'b0},  // space pairs at both ends
      '{8'hFF, 1'b0, ROW_PREDICTED, 4'd0,  8'h00, 1'b0},
      '{8'h01, 1'b0, ROW_TYPED,     4'd0,  8'h00, 1'b0},  // shortest raw run
      '{8'hAB, 1'b0, ROW_TYPED,     4'd1,  8'hAB, 1'b0},
      '{8'h08, 1'b0, ROW_TYPED,     4'd0,  8'h00, 1'b0},  // longest raw run of token bytes
      '{8'h00, 1'b0, ROW_TYPED,     4'd1,  8'h00, 1'b0},
      '{8'hFF, 1'b0, ROW_TYPED,     4'd1,  8'hFF, 1'b0},
      '{8'hC0, 1'b0, ROW_TYPED,     4'd1,  8'hC0, 1'b0},
      '{8'h80, 1'b0, ROW_TYPED,     4'd1,  8'h80, 1'b0},
      '{8'h01, 1'b0, ROW_TYPED,     4'd1,  8'h01, 1'b0},
      '{8'h55, 1'b0, ROW_TYPED,     4'd1,  8'h55, 1'b0},
      '{8'hAA, 1'b0, ROW_TYPED,     4'd1,  8'hAA, 1'b0},
      '{8'h7F, 1'b0, ROW_TYPED,     4'd1,  8'h7F, 1'b0},
      '{8'h85, 1'b1, ROW_TYPED,     4'd0,  8'h00, 1'b0},  // record ends on a half reference
      '{8'h80, 1'b0, ROW_TYPED,     4'd0,  8'h00, 1'b0},
      '{8'h0B, 1'b0, ROW_TYPED,     4'd6,  8'h00, 1'b1}   // reference into an empty record
   };

   // Decoder state, mirrored from the accepted request transfers.
   logic [7:0]   hist_mem [RECORD_BYTES];
   int unsigned  wr_pos     = 0;
   int unsigned  raw_count  = 0;
   logic [7:0]   ref_high   = 8'h00;
   bit           ref_open   = 1'b0;
   out_byte_type pending_out [$];

   int  error_count     = 0;
   int  items_sent      = 0;
   int  results_checked = 0;
   int  records_closed  = 0;
   int  bad_results     = 0;
   int  dropped_bytes   = 0;
   int  last_made       = 0;
   bit  calm            = 1'b0;
   bit  hold_pending    = 1'b0;

   task automatic note_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Short gaps are common, long ones rare; none at all in a calm stretch.
   function automatic int next_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Stores one byte in the record and queues it, unless the record is full.
   function automatic void emit_byte(logic [7:0] b, logic bad);
      if (wr_pos >= RECORD_BYTES) begin
         dropped_bytes++;
         return;
      end
      hist_mem[wr_pos] = b;
      wr_pos++;
      pending_out.push_back('{data: b, run_end: 1'b0, bad: bad});
   endfunction

   // Decodes one compressed byte and queues what it produces.
   function automatic int decode_byte(logic [7:0] c, logic rec_last);
      logic [15:0] word;
      int unsigned ref_dist;
      int unsigned len;
      logic        bad_ref;
      logic [7:0]  b;
      int          start;
      int          made;
      start = pending_out.size();
      if (raw_count > 0) begin
         raw_count--;
         emit_byte(c, 1'b0);
      end else if (ref_open) begin
         word     = {ref_high, c};
         ref_dist = (word & WORD_MASK) >> LENGTH_BITS;
         len      = (word & MAX_LEN_CODE) + LEN_BIAS;
         bad_ref  = (ref_dist == 0) || (ref_dist > wr_pos);
         ref_open = 1'b0;
         // Source reads walk forward with the write position, so a short
         // distance repeats the bytes this copy has just written.
         for (int k = 0; k < len; k++) begin
            b = 8'h00;
            if (!bad_ref && wr_pos < RECORD_BYTES)
               b = hist_mem[(wr_pos - ref_dist) % RECORD_BYTES];
            emit_byte(b, bad_ref);
         end
      end else if (c >= 8'h01 && c <= RAW_MAX) begin
         raw_count = c;
      end else if (c <= LITERAL_MAX) begin
         emit_byte(c, 1'b0);
      end else if (c >= PAIR_MIN) begin
         emit_byte(SPACE_CHAR, 1'b0);
         emit_byte(c ^ PAIR_FLIP, 1'b0);
      end else begin
         ref_high = c;
         ref_open = 1'b1;
      end
      made = pending_out.size() - start;
      if (made > 0) pending_out[pending_out.size() - 1].run_end = 1'b1;
      if (rec_last) begin
         wr_pos    = 0;
         raw_count = 0;
         ref_open  = 1'b0;
         records_closed++;
      end
      return made;
   endfunction

   // Offers one byte after a random gap and decodes it once it is taken.
   task automatic send_item(input logic [7:0] c, input logic rec_last);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= rec_last;
      do @(posedge clock); while (!req_tready);
      last_made = decode_byte(c, rec_last);
      items_sent++;
   endtask

   task automatic send_backref(input int unsigned ref_dist, input int unsigned len_code,
                               input logic head_last, input logic tail_last);
      logic [13:0] word14;
      word14 = 14'((ref_dist << LENGTH_BITS) | len_code);
      send_item({2'b10, word14[13:8]}, head_last);
      send_item(word14[7:0], tail_last);
   endtask

   // Picks a distance that lies inside the written part of the record, or,
   // when asked for a bad one, zero or beyond the write position.
   function automatic int unsigned pick_distance(bit want_bad);
      int unsigned lim;
      if (want_bad) begin
         if (wr_pos < MAX_DIST && $urandom_range(0, 1) == 1)
            return $urandom_range(wr_pos + 1, MAX_DIST);
         return 0;
      end
      lim = (wr_pos < MAX_DIST) ? wr_pos : MAX_DIST;
      if (lim == 0) return 0;
      if ($urandom_range(0, 1) == 1) return $urandom_range(1, (lim < 8) ? lim : 8);
      return $urandom_range(1, lim);
   endfunction

   function automatic logic stray_end();
      return ($urandom_range(0, 149) == 0);
   endfunction

   // One token: mostly well formed, sometimes a random byte, and now and
   // then a record end that may cut a token in half.
   task automatic random_token();
      int         r;
      int         n;
      logic       tok_end;
      logic [7:0] v;
      r = $urandom_range(0, 99);
      tok_end = ($urandom_range(0, 29) == 0);
      if (r < 25) begin
         v = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(9, LITERAL_MAX));
         send_item(v, tok_end);
      end else if (r < 40) begin
         n = $urandom_range(1, RAW_MAX);
         send_item(8'(n), stray_end());
         for (int k = 0; k < n; k++)
            send_item(8'($urandom_range(0, 255)), (k == n - 1) ? tok_end : stray_end());
      end else if (r < 55) begin
         send_item(8'($urandom_range(PAIR_MIN, 255)), tok_end);
      end else if (r < 90) begin
         send_backref(pick_distance($urandom_range(0, 9) == 0),
                      $urandom_range(0, MAX_LEN_CODE), stray_end(), tok_end);
      end else begin
         send_item(8'($urandom_range(0, 255)), stray_end());
      end
   endtask

   // Sender stops and waits for every queued response to arrive.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_out.size() != 0);
   endtask

   // Response checker: compares each transfer with the oldest queued byte.
   always @(posedge clock) begin
      out_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (rsp_tuser) bad_results++;
         if (pending_out.size() == 0) begin
            note_error($sformatf("unexpected response data=%02h last=%0b bad=%0b",
                                 rsp_tdata, rsp_tlast, rsp_tuser));
         end else begin
            want = pending_out.pop_front();
            if (rsp_tdata !== want.data)
               note_error($sformatf("out_byte %02h, expected %02h", rsp_tdata, want.data));
            if (rsp_tlast !== want.run_end)
               note_error($sformatf("last_of_run %0b, expected %0b", rsp_tlast,
                                    want.run_end));
            if (rsp_tuser !== want.bad)
               note_error($sformatf("bad_distance %0b, expected %0b", rsp_tuser, want.bad));
         end
      end
   end

   // Response side: random stalls, plus one long hold-off on request that
   // backs the block up until it refuses input.
   initial begin : receiver
      int stall;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = next_gap();
         if (stall == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("ERROR: run did not finish in time");
      $display("testbench: errors");
      $finish;
   end

   initial begin : stimulus
      int  random_base;
      int  done;
      bit  hold_fired;
      bit  drained;
      hold_fired = 1'b0;
      drained    = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Typed rows replace the decoder's bytes with the
      // literal response written in the row.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_item(directed_rows[i].data, directed_rows[i].rec_last);
         if (directed_rows[i].kind == ROW_TYPED) begin
            repeat (last_made) void'(pending_out.pop_back());
            for (int k = 0; k < directed_rows[i].count; k++)
               pending_out.push_back('{data: directed_rows[i].val,
                                      run_end: (k == directed_rows[i].count - 1),
                                      bad: directed_rows[i].bad});
         end
      end
      drain_results();

      // Fill the record with long back-references until it is full, then
      // send tokens whose bytes must all be dropped, and close the record.
      while (wr_pos < RECORD_BYTES)
         send_backref(pick_distance(1'b0), MAX_LEN_CODE, 1'b0, 1'b0);
      send_item(8'h41, 1'b0);
      send_item(8'hC5, 1'b0);
      send_backref(pick_distance(1'b0), 2, 1'b0, 1'b0);
      send_backref(0, 0, 1'b0, 1'b0);
      send_item(8'h02, 1'b0);
      send_item(8'h11, 1'b0);
      send_item(8'h22, 1'b1);
      drain_results();

      // Random mix with a long output hold-off early, a stretch without any
      // idling on either side, and one full drain.
      random_base = items_sent;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         done = items_sent - random_base;
         if (!hold_fired && done >= 60) begin
            hold_pending = 1'b1;
            hold_fired   = 1'b1;
         end
         calm = (done >= 200 && done < 300);
         if (!drained && done >= 350) begin
            drain_results();
            drained = 1'b1;
         end
         random_token();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_out.size() != 0)
         note_error($sformatf("%0d responses never arrived", pending_out.size()));

      $display("Sent %0d request transfers over %0d records; checked %0d responses.",
               items_sent, records_closed, results_checked);
      $display("Saw %0d bad-distance bytes; %0d bytes dropped past a full record.",
               bad_results, dropped_bytes);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

// ===== files.f =====
src/lz77rd_pkg.sv
src/lz77rd_hist_mem.sv
src/lz77rd_engine.sv
src/lz77_record_decompressor.sv
bench/testbench.sv
